FILE: hw/rtl/wgm_pkg.sv
// Package for the wildcard glob matcher.
// Holds the word kinds, glob characters, FSM states and controller/datapath structs.
// No dependencies.
package wgm_pkg;

	localparam int DEF_MAX_PATTERN = 32;
	localparam int DEF_MAX_TEXT    = 64;

	localparam logic [7:0] CHAR_ANY_ONE = 8'h3F;
	localparam logic [7:0] CHAR_ANY_RUN = 8'h2A;

	typedef enum logic [1:0] {
		KIND_CLEAR    = 2'd0,
		KIND_APP_PAT  = 2'd1,
		KIND_APP_TXT  = 2'd2,
		KIND_EVAL     = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_CMP,
		ST_TFETCH,
		ST_TCMP,
		ST_RESULT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_APP_PAT,
		OP_APP_TXT,
		OP_START,
		OP_ADV,
		OP_STAR,
		OP_BACK,
		OP_TAIL
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   verdict_we;
		logic   verdict;
		logic   out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic ti_lt_n;
		logic pi_lt_m;
		logic p_one;
		logic p_star;
		logic p_eq_t;
		logic have_star;
		logic drop;
		logic out_busy;
	} dp_stat_t;

endpackage

FILE: hw/rtl/wildcard_glob_matcher.sv
// Top level of the wildcard glob matcher: joins controller and datapath.
// Depends on wgm_pkg, wgm_ctrl, wgm_dp.
//
//   channel  handshake            word fields
//   in       in_valid / in_stall  kind[1:0], byte_value[7:0]
//   out      out_valid/ out_stall matched, overflow
//
// Clear and append words are taken while idle and leave the block idle.
// Evaluate is accepted while idle, then walks the buffers in match steps of a memory
// read (FETCH) and a compare (CMP), then scans trailing stars (TFETCH, TCMP); RESULT
// then loads the result word, waiting while a pending result is stalled; an overflowed
// evaluate skips the walk and goes straight to RESULT.
// arst_n clears lengths, overflow flag, FSM and result valid; buffer contents are kept.
// A pending result waits under out_stall; loads are still taken meanwhile.
module wildcard_glob_matcher
	import wgm_pkg::*;
#(
	parameter int MAX_PATTERN = DEF_MAX_PATTERN,
	parameter int MAX_TEXT    = DEF_MAX_TEXT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [7:0] byte_value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       matched,
	output logic       overflow
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	wgm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	wgm_dp #(
		.MAX_PATTERN (MAX_PATTERN),
		.MAX_TEXT    (MAX_TEXT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_value (byte_value),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.matched    (matched),
		.overflow   (overflow)
	);

endmodule

FILE: hw/rtl/wgm_dp.sv
// Datapath of the wildcard glob matcher: pattern and text buffers, match indices,
// star bookkeeping and the result word register.
// Depends on wgm_pkg.
module wgm_dp
	import wgm_pkg::*;
#(
	parameter int MAX_PATTERN = DEF_MAX_PATTERN,
	parameter int MAX_TEXT    = DEF_MAX_TEXT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] byte_value,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       matched,
	output logic       overflow
);

	localparam int PLW = $clog2(MAX_PATTERN + 1);
	localparam int TLW = $clog2(MAX_TEXT + 1);
	localparam int PAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int TAW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;

	logic [7:0] pat_mem [MAX_PATTERN];
	logic [7:0] txt_mem [MAX_TEXT];

	logic [PLW-1:0] plen_q, pi_q, star_q;
	logic [TLW-1:0] tlen_q, ti_q, resume_q;
	logic           have_star_q, drop_q, verdict_q;
	logic [7:0]     pdata_q, tdata_q;
	logic           out_valid_q, matched_q, overflow_q;

	logic pat_full, txt_full;
	assign pat_full = (plen_q == PLW'(MAX_PATTERN));
	assign txt_full = (tlen_q == TLW'(MAX_TEXT));

	always_ff @(posedge clk) begin
		if (cmd.op == OP_APP_PAT && !pat_full) begin
			pat_mem[plen_q[PAW-1:0]] <= byte_value;
		end
		if (cmd.op == OP_APP_TXT && !txt_full) begin
			txt_mem[tlen_q[TAW-1:0]] <= byte_value;
		end
	end

	always_ff @(posedge clk) begin
		pdata_q <= pat_mem[pi_q[PAW-1:0]];
		tdata_q <= txt_mem[ti_q[TAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q      <= '0;
			tlen_q      <= '0;
			drop_q      <= 1'b0;
			pi_q        <= '0;
			ti_q        <= '0;
			star_q      <= '0;
			resume_q    <= '0;
			have_star_q <= 1'b0;
			verdict_q   <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_CLEAR: begin
					plen_q <= '0;
					tlen_q <= '0;
					drop_q <= 1'b0;
				end
				OP_APP_PAT: begin
					if (pat_full) drop_q <= 1'b1;
					else          plen_q <= plen_q + PLW'(1);
				end
				OP_APP_TXT: begin
					if (txt_full) drop_q <= 1'b1;
					else          tlen_q <= tlen_q + TLW'(1);
				end
				OP_START: begin
					pi_q        <= '0;
					ti_q        <= '0;
					have_star_q <= 1'b0;
				end
				OP_ADV: begin
					pi_q <= pi_q + PLW'(1);
					ti_q <= ti_q + TLW'(1);
				end
				OP_STAR: begin
					have_star_q <= 1'b1;
					star_q      <= pi_q;
					resume_q    <= ti_q;
					pi_q        <= pi_q + PLW'(1);
				end
				OP_BACK: begin
					pi_q     <= star_q + PLW'(1);
					resume_q <= resume_q + TLW'(1);
					ti_q     <= resume_q + TLW'(1);
				end
				OP_TAIL: begin
					pi_q <= pi_q + PLW'(1);
				end
				default: begin
				end
			endcase
			if (cmd.verdict_we) verdict_q <= cmd.verdict;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			matched_q  <= verdict_q && !drop_q;
			overflow_q <= drop_q;
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;
	assign overflow  = overflow_q;

	always_comb begin
		stat.ti_lt_n   = (ti_q < tlen_q);
		stat.pi_lt_m   = (pi_q < plen_q);
		stat.p_one     = (pdata_q == CHAR_ANY_ONE);
		stat.p_star    = (pdata_q == CHAR_ANY_RUN);
		stat.p_eq_t    = (pdata_q == tdata_q);
		stat.have_star = have_star_q;
		stat.drop      = drop_q;
		stat.out_busy  = out_valid_q && out_stall;
	end

endmodule

FILE: hw/rtl/wgm_ctrl.sv
// Controller of the wildcard glob matcher: sequences loads, the greedy match walk
// with star backtracking, the trailing star scan and the result hand-off.
// Depends on wgm_pkg.
module wgm_ctrl
	import wgm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] kind,
	output logic       in_stall,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && kind == KIND_EVAL) begin
					state_d = stat.drop ? ST_RESULT : ST_FETCH;
				end
			end
			ST_FETCH:  state_d = stat.ti_lt_n ? ST_CMP : ST_TFETCH;
			ST_CMP: begin
				priority if (stat.pi_lt_m && (stat.p_one || stat.p_eq_t)) state_d = ST_FETCH;
				else if (stat.pi_lt_m && stat.p_star)                      state_d = ST_FETCH;
				else if (stat.have_star)                                   state_d = ST_FETCH;
				else                                                        state_d = ST_RESULT;
			end
			ST_TFETCH: state_d = stat.pi_lt_m ? ST_TCMP : ST_RESULT;
			ST_TCMP:   state_d = stat.p_star ? ST_TFETCH : ST_RESULT;
			ST_RESULT: if (!stat.out_busy) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '{op: OP_NONE, verdict_we: 1'b0, verdict: 1'b0, out_load: 1'b0};
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (kind_t'(kind))
						KIND_CLEAR:   cmd.op = OP_CLEAR;
						KIND_APP_PAT: cmd.op = OP_APP_PAT;
						KIND_APP_TXT: cmd.op = OP_APP_TXT;
						KIND_EVAL: begin
							if (stat.drop) cmd.verdict_we = 1'b1;
							else           cmd.op = OP_START;
						end
						default: cmd.op = OP_NONE;
					endcase
				end
			end
			ST_FETCH: begin
			end
			ST_CMP: begin
				priority if (stat.pi_lt_m && (stat.p_one || stat.p_eq_t)) cmd.op = OP_ADV;
				else if (stat.pi_lt_m && stat.p_star)                      cmd.op = OP_STAR;
				else if (stat.have_star)                                   cmd.op = OP_BACK;
				else                                                        cmd.verdict_we = 1'b1;
			end
			ST_TFETCH: begin
				if (!stat.pi_lt_m) begin
					cmd.verdict_we = 1'b1;
					cmd.verdict    = 1'b1;
				end
			end
			ST_TCMP: begin
				if (stat.p_star) cmd.op = OP_TAIL;
				else             cmd.verdict_we = 1'b1;
			end
			ST_RESULT: cmd.out_load = !stat.out_busy;
			default: begin
			end
		endcase
	end

endmodule

FILE: hw/rtl/wgm_checker.sv
// Port-level checks for the wildcard glob matcher, bound to the top level.
// Depends on wgm_pkg and wildcard_glob_matcher.
module wgm_checker
	import wgm_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] kind,
	input logic       out_valid,
	input logic       out_stall,
	input logic       matched,
	input logic       overflow
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(matched) && $stable(overflow))
		else $error("result word changed while stalled");

	a_ovf_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(matched && overflow))
		else $error("overflowed result reports a match");

	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind == KIND_EVAL |=> in_stall)
		else $error("evaluate word did not occupy the block");

	a_load_single: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind != KIND_EVAL |=> !in_stall)
		else $error("load word took more than one cycle");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.kind      (kind),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.matched   (matched),
	.overflow  (overflow)
);
